// ===== design/dual_wavetable_oscillator_mix_macros.svh =====
// Assertion macros shared by the dual wavetable oscillator mixer.
`ifndef DUAL_WAVETABLE_OSCILLATOR_MIX_MACROS_SVH
`define DUAL_WAVETABLE_OSCILLATOR_MIX_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DWO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dwo assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DWO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dwo assertion failed");

`endif

// ===== design/dwo_pkg.sv =====
// Shared types, constants and codes of the dual wavetable oscillator mixer.
package dwo_pkg;

  localparam int unsigned WAVE_DEPTH = 16384;
  localparam int unsigned ADDR_W     = $clog2(WAVE_DEPTH);
  localparam int unsigned PHASE_BITS = 32;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned LEN_W      = 15;
  localparam int unsigned POS_W      = 30;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TIDX_W     = POS_W - FRAC_W;
  localparam int unsigned MIX_W      = 8;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [MIX_W-1:0] MIX_RESET = 8'd128;
  localparam logic [MIX_W-1:0] MIX_MAX   = 8'd255;

  // Division by 255 through a reciprocal, exact for magnitudes below 2^24.
  localparam int unsigned SUM_W     = SAMPLE_W + MIX_W + 2;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned RECIP_W   = 25;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd16843010;
  localparam int unsigned DIV_SHIFT = 32;
  localparam int unsigned QPROD_W   = MAG_W + RECIP_W;

  localparam int unsigned FQ_DEPTH  = 4;
  localparam int unsigned FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_LVL_W  = $clog2(FQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH  = 2;
  localparam int unsigned OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_LVL_W  = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_KILL    = 2'd2,
    CMD_TICK    = 2'd3
  } dwo_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_A = 3'd0,
    REG_STEP_B = 3'd1,
    REG_LEN_A  = 3'd2,
    REG_LEN_B  = 3'd3,
    REG_POS_A  = 3'd4,
    REG_POS_B  = 3'd5,
    REG_MIX    = 3'd6
  } dwo_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LERP,
    ST_MORPH,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } dwo_state_e;

  typedef struct packed {
    dwo_cmd_e                   cmd;
    logic                       osc;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value;
  } dwo_op_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_a;
    logic [STEP_W-1:0] step_b;
    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  len_b;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
    logic [MIX_W-1:0]  mix;
  } dwo_cfg_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    dwo_state_e          state;
  } dwo_osc_ctrl_t;

endpackage

// ===== design/dwo_ram.sv =====
// Generic single-port RAM with a registered read.
module dwo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dwo_front.sv =====
// Input side: accepts and classifies commands into a short queue for the sequencer.
module dwo_front import dwo_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [CMD_W-1:0]           command_i,
  input  logic                       oscillator_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic signed [SAMPLE_W-1:0] wave_value_i,
  output logic                       op_valid_o,
  input  logic                       op_ready_i,
  output dwo_op_t                    op_o,
  output logic [FQ_LVL_W-1:0]        level_o
);

  dwo_op_t               entry_q [FQ_DEPTH];
  dwo_op_t               new_op;
  logic [FQ_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FQ_LVL_W-1:0]   level_q, level_d;
  logic                  push_ok, pop_ok;

  assign new_op = '{cmd: dwo_cmd_e'(command_i), osc: oscillator_i,
                    addr: address_i, value: wave_value_i};

  assign full       = (level_q == FQ_LVL_W'(FQ_DEPTH));
  assign op_valid_o = (level_q != '0);
  assign op_o       = entry_q[rd_q];
  assign level_o    = level_q;
  assign push_ok    = push && !full;
  assign pop_ok     = op_valid_o && op_ready_i;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    level_d = level_q;
    if (push_ok) begin
      wr_d = (wr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      level_d = level_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_q] <= new_op;
    end
  end

endmodule

// ===== design/dwo_osc.sv =====
// One wavetable oscillator: wave store, frame addressing, interpolation and morph.
module dwo_osc import dwo_pkg::*; (
  input  logic                       clk_i,
  input  dwo_osc_ctrl_t              ctrl_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  logic [LEN_W-1:0]           len_i,
  input  logic [POS_W-1:0]           pos_i,
  output logic signed [SAMPLE_W-1:0] value_o
);

  localparam int unsigned PROD_W  = PHASE_BITS + LEN_W;
  localparam int unsigned START_W = TIDX_W + LEN_W;

  function automatic logic signed [SAMPLE_W-1:0] lerp(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRAC_W-1:0]          f
  );
    logic signed [SAMPLE_W:0]          d;
    logic signed [SAMPLE_W+FRAC_W+1:0] p;
    d = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
    p = d * $signed({1'b0, f});
    return SAMPLE_W'(a + p[FRAC_W +: SAMPLE_W]);
  endfunction

  logic [LEN_W-1:0]           count_c, count_q;
  logic [PROD_W-1:0]          prod_q;
  logic [START_W-1:0]         start_q;
  logic [LEN_W-1:0]           frame_c, frame_inc_c, next_c, frame_q, next_q;
  logic [FRAC_W-1:0]          frac_q;
  logic [START_W:0]           start2_c;
  logic [START_W+1:0]         end_c;
  logic [ADDR_W-1:0]          lo_q, hi_q, rd_addr_c, ram_addr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] w0_q, w1_q, w2_q, base_q, other_q, value_q;
  logic [FRAC_W-1:0]          morph;

  assign count_c     = (len_i > LEN_W'(WAVE_DEPTH)) ? LEN_W'(WAVE_DEPTH) : len_i;
  assign morph       = pos_i[FRAC_W-1:0];
  assign frame_c     = prod_q[PROD_W-1 -: LEN_W];
  assign frame_inc_c = frame_c + 1'b1;
  assign next_c      = (frame_inc_c == count_q) ? '0 : frame_inc_c;
  assign start2_c    = {1'b0, start_q} + count_q;
  assign end_c       = {1'b0, start2_c} + count_q;

  always_comb begin
    case (ctrl_i.state)
      ST_RD0:  rd_addr_c = lo_q + frame_q[ADDR_W-1:0];
      ST_RD1:  rd_addr_c = lo_q + next_q[ADDR_W-1:0];
      ST_RD2:  rd_addr_c = hi_q + frame_q[ADDR_W-1:0];
      ST_RD3:  rd_addr_c = hi_q + next_q[ADDR_W-1:0];
      default: rd_addr_c = '0;
    endcase
  end

  assign ram_addr = ctrl_i.we ? ctrl_i.waddr : rd_addr_c;

  dwo_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WAVE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.we),
    .addr_i (ram_addr),
    .wdata_i(ctrl_i.wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    case (ctrl_i.state)
      ST_MUL: begin
        prod_q  <= phase_i * count_c;
        start_q <= pos_i[POS_W-1:FRAC_W] * count_c;
        count_q <= count_c;
      end
      ST_ADDR: begin
        frame_q <= frame_c;
        next_q  <= next_c;
        frac_q  <= prod_q[PHASE_BITS-1 -: FRAC_W];
        lo_q    <= start_q[ADDR_W-1:0];
        hi_q    <= (end_c > (START_W + 2)'(WAVE_DEPTH)) ? '0 : start2_c[ADDR_W-1:0];
      end
      ST_RD1: w0_q <= rdata;
      ST_RD2: w1_q <= rdata;
      ST_RD3: w2_q <= rdata;
      ST_LERP: begin
        base_q  <= lerp(w0_q, w1_q, frac_q);
        other_q <= lerp(w2_q, rdata, frac_q);
      end
      ST_MORPH: begin
        if (count_q == '0) begin
          value_q <= '0;
        end else if (morph == '0) begin
          value_q <= base_q;
        end else begin
          value_q <= lerp(base_q, other_q, morph);
        end
      end
      default: ;
    endcase
  end

  assign value_o = value_q;

endmodule

// ===== design/dwo_back.sv =====
// Sequencer side: executes commands, runs both oscillators, mixes and queues results.
module dwo_back import dwo_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  output logic                       op_ready_o,
  input  dwo_op_t                    op_i,
  input  dwo_cfg_t                   cfg_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] sample_value_o,
  output logic                       voice_on_o
);

  dwo_state_e                 state_q, state_d;
  logic [PHASE_BITS-1:0]      phase_a_q, phase_b_q;
  logic                       active_q;
  logic                       load_a, load_b, note_on, kill, advance;
  logic                       res_push, res_on, room, res_pop;
  logic [SAMPLE_W-1:0]        res_val;
  dwo_osc_ctrl_t              ctrl_a, ctrl_b;
  logic signed [SAMPLE_W-1:0] va, vb;
  logic signed [MIX_W:0]      wa_c, wb_c;
  logic signed [SUM_W-1:0]    mix_sum_c, sum_q;
  logic [SUM_W-1:0]           mag_c;
  logic [QPROD_W-1:0]         qprod_c;
  logic [SAMPLE_W:0]          quo_q, sres_c;
  logic                       neg_q;
  logic [SAMPLE_W-1:0]        res_val_q [OQ_DEPTH];
  logic                       res_on_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]        owr_q, ord_q;
  logic [OQ_LVL_W-1:0]        olvl_q, olvl_d;

  assign room    = (olvl_q != OQ_LVL_W'(OQ_DEPTH));
  assign empty   = (olvl_q == '0);
  assign res_pop = pop && !empty;

  always_comb begin
    state_d    = state_q;
    op_ready_o = 1'b0;
    load_a     = 1'b0;
    load_b     = 1'b0;
    note_on    = 1'b0;
    kill       = 1'b0;
    advance    = 1'b0;
    res_push   = 1'b0;
    res_on     = 1'b0;
    res_val    = '0;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          case (op_i.cmd)
            CMD_LOAD: begin
              op_ready_o = 1'b1;
              load_a     = !op_i.osc;
              load_b     = op_i.osc;
            end
            CMD_NOTE_ON: begin
              op_ready_o = 1'b1;
              note_on    = 1'b1;
            end
            CMD_KILL: begin
              op_ready_o = 1'b1;
              kill       = 1'b1;
            end
            CMD_TICK: begin
              if (room) begin
                op_ready_o = 1'b1;
                if (active_q) begin
                  state_d = ST_MUL;
                end else begin
                  res_push = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL:   state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_LERP;
      ST_LERP:  state_d = ST_MORPH;
      ST_MORPH: state_d = ST_MIX;
      ST_MIX:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_OUT;
      ST_OUT: begin
        res_push = 1'b1;
        res_on   = 1'b1;
        res_val  = sres_c[SAMPLE_W-1:0];
        advance  = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ctrl_a = '{we: load_a, waddr: op_i.addr, wdata: op_i.value, state: state_q};
  assign ctrl_b = '{we: load_b, waddr: op_i.addr, wdata: op_i.value, state: state_q};

  dwo_osc u_osc_a (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_a),
    .phase_i(phase_a_q),
    .len_i  (cfg_i.len_a),
    .pos_i  (cfg_i.pos_a),
    .value_o(va)
  );

  dwo_osc u_osc_b (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_b),
    .phase_i(phase_b_q),
    .len_i  (cfg_i.len_b),
    .pos_i  (cfg_i.pos_b),
    .value_o(vb)
  );

  assign wa_c      = {1'b0, MIX_MAX - cfg_i.mix};
  assign wb_c      = {1'b0, cfg_i.mix};
  assign mix_sum_c = va * wa_c + vb * wb_c;
  assign mag_c     = sum_q[SUM_W-1] ? -sum_q : sum_q;
  assign qprod_c   = mag_c[MAG_W-1:0] * DIV_RECIP;
  assign sres_c    = neg_q ? -quo_q : quo_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MIX) begin
      sum_q <= mix_sum_c;
    end
    if (state_q == ST_DIV) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= qprod_c[DIV_SHIFT +: SAMPLE_W + 1];
    end
    if (res_push) begin
      res_val_q[owr_q] <= res_val;
      res_on_q[owr_q]  <= res_on;
    end
  end

  always_comb begin
    olvl_d = olvl_q;
    if (res_push && !res_pop) begin
      olvl_d = olvl_q + 1'b1;
    end else if (res_pop && !res_push) begin
      olvl_d = olvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_a_q <= '0;
      phase_b_q <= '0;
      active_q  <= 1'b0;
      owr_q     <= '0;
      ord_q     <= '0;
      olvl_q    <= '0;
    end else begin
      state_q <= state_d;
      olvl_q  <= olvl_d;
      if (note_on) begin
        phase_a_q <= '0;
        phase_b_q <= '0;
        active_q  <= 1'b1;
      end else if (kill) begin
        active_q <= 1'b0;
      end else if (advance) begin
        phase_a_q <= phase_a_q + cfg_i.step_a;
        phase_b_q <= phase_b_q + cfg_i.step_b;
      end
      if (res_push) begin
        owr_q <= (owr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : owr_q + 1'b1;
      end
      if (res_pop) begin
        ord_q <= (ord_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : ord_q + 1'b1;
      end
    end
  end

  assign sample_value_o = res_val_q[ord_q];
  assign voice_on_o     = res_on_q[ord_q];

endmodule

// ===== design/dual_wavetable_oscillator_mix.sv =====
// Top level: configuration registers, input queue, sequencer and assertions.
// A load, note-on or kill is executed as the idle sequencer takes it from the input queue.
// A sample tick of an active voice passes through acceptance, multiply,
// frame addressing, four reads on each single-port wave store, two interpolation stages,
// mix, divide by 255 and output; no new command is taken until the tick is through.
// Reset clears phases, voice, both queues and configuration (mix 128), not the wave stores.
`include "dual_wavetable_oscillator_mix_macros.svh"

module dual_wavetable_oscillator_mix import dwo_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [CMD_W-1:0]           command_i,
  input  logic                       oscillator_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic signed [SAMPLE_W-1:0] wave_value_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] sample_value_o,
  output logic                       voice_on_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  dwo_cfg_t              cfg_q;
  dwo_op_t               op;
  logic                  op_valid, op_ready;
  logic [FQ_LVL_W-1:0]   fq_level;
  logic                  fq_grow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_a <= '0;
      cfg_q.step_b <= '0;
      cfg_q.len_a  <= '0;
      cfg_q.len_b  <= '0;
      cfg_q.pos_a  <= '0;
      cfg_q.pos_b  <= '0;
      cfg_q.mix    <= MIX_RESET;
    end else if (cfg_we_i) begin
      case (dwo_reg_e'(cfg_index_i))
        REG_STEP_A: cfg_q.step_a <= cfg_data_i[STEP_W-1:0];
        REG_STEP_B: cfg_q.step_b <= cfg_data_i[STEP_W-1:0];
        REG_LEN_A:  cfg_q.len_a  <= cfg_data_i[LEN_W-1:0];
        REG_LEN_B:  cfg_q.len_b  <= cfg_data_i[LEN_W-1:0];
        REG_POS_A:  cfg_q.pos_a  <= cfg_data_i[POS_W-1:0];
        REG_POS_B:  cfg_q.pos_b  <= cfg_data_i[POS_W-1:0];
        REG_MIX:    cfg_q.mix    <= cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  dwo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .oscillator_i(oscillator_i),
    .address_i   (address_i),
    .wave_value_i(wave_value_i),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_o        (op),
    .level_o     (fq_level)
  );

  dwo_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_ready_o    (op_ready),
    .op_i          (op),
    .cfg_i         (cfg_q),
    .empty         (empty),
    .pop           (pop),
    .sample_value_o(sample_value_o),
    .voice_on_o    (voice_on_o)
  );

  assign fq_grow = push && !full && !(op_valid && op_ready);

  `DWO_ASSERT_IMP(a_inactive_is_silent, !empty && !voice_on_o, sample_value_o == '0)
  `DWO_ASSERT_NEXT(a_queue_fills, fq_grow, fq_level == $past(fq_level) + 1'b1)

endmodule

// ===== bench/dual_wavetable_oscillator_mix_tb.sv =====
// Self-checking testbench for the dual wavetable oscillator mixer with its own sample predictor.
module dual_wavetable_oscillator_mix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwo_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       voice;
  } tick_result_t;

  typedef struct packed {
    logic [3:0][ADDR_W-1:0] addr;
    logic [FRAC_W-1:0]      frac;
  } wave_taps_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       push         = 1'b0;
  logic                       full;
  logic [CMD_W-1:0]           command_i    = '0;
  logic                       oscillator_i = 1'b0;
  logic [ADDR_W-1:0]          address_i    = '0;
  logic signed [SAMPLE_W-1:0] wave_value_i = '0;
  logic                       empty;
  logic                       pop          = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_value_o;
  logic                       voice_on_o;
  logic                       cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i  = '0;
  logic [CFG_W-1:0]           cfg_data_i   = '0;

  dwo_cfg_t                   cfg_model;
  logic [PHASE_BITS-1:0]      osc_phase [2];
  logic                       voice_live;
  logic signed [SAMPLE_W-1:0] wave_mem [2][WAVE_DEPTH];
  bit                         wave_known [2][WAVE_DEPTH];
  tick_result_t               expected_samples [$];
  int unsigned                send_idle_pct = 0;
  int unsigned                pop_stall_pct = 0;
  int                         mismatches    = 0;

  dual_wavetable_oscillator_mix u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .oscillator_i   (oscillator_i),
    .address_i      (address_i),
    .wave_value_i   (wave_value_i),
    .empty          (empty),
    .pop            (pop),
    .sample_value_o (sample_value_o),
    .voice_on_o     (voice_on_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  function automatic wave_taps_t locate_taps(bit o);
    logic [63:0]      count;
    logic [63:0]      prod;
    logic [63:0]      frame;
    logic [63:0]      next_frame;
    logic [63:0]      start;
    logic [63:0]      start2;
    logic [POS_W-1:0] pos;
    wave_taps_t       t;
    count = o ? 64'(cfg_model.len_b) : 64'(cfg_model.len_a);
    pos   = o ? cfg_model.pos_b : cfg_model.pos_a;
    if (count > WAVE_DEPTH) count = WAVE_DEPTH;
    prod       = 64'(osc_phase[o]) * count;
    frame      = prod >> PHASE_BITS;
    t.frac     = prod[PHASE_BITS-1 -: FRAC_W];
    next_frame = (frame + 1 == count) ? 64'd0 : frame + 1;
    start      = 64'(pos[POS_W-1:FRAC_W]) * count;
    start2     = start + count;
    if (start2 + count > WAVE_DEPTH) start2 = 0;
    t.addr[0] = ADDR_W'(start + frame);
    t.addr[1] = ADDR_W'(start + next_frame);
    t.addr[2] = ADDR_W'(start2 + frame);
    t.addr[3] = ADDR_W'(start2 + next_frame);
    return t;
  endfunction

  // Linear step from a towards b, rounded towards minus infinity.
  function automatic int blend(int a, int b, logic [FRAC_W-1:0] f);
    longint d;
    d = longint'(b - a) * longint'(f);
    return a + int'(d >>> FRAC_W);
  endfunction

  function automatic int osc_level(bit o);
    wave_taps_t        t;
    logic [FRAC_W-1:0] morph;
    logic [LEN_W-1:0]  len;
    int                base_v;
    int                other_v;
    t     = locate_taps(o);
    morph = o ? cfg_model.pos_b[FRAC_W-1:0] : cfg_model.pos_a[FRAC_W-1:0];
    len   = o ? cfg_model.len_b : cfg_model.len_a;
    if (len == 0) return 0;
    base_v = blend(wave_mem[o][t.addr[0]], wave_mem[o][t.addr[1]], t.frac);
    if (morph == 0) return base_v;
    other_v = blend(wave_mem[o][t.addr[2]], wave_mem[o][t.addr[3]], t.frac);
    return blend(base_v, other_v, morph);
  endfunction

  function automatic void predict_op(dwo_op_t op);
    tick_result_t r;
    longint       acc;
    int           wa;
    int           wb;
    case (op.cmd)
      CMD_LOAD: begin
        wave_mem[op.osc][op.addr]   = op.value;
        wave_known[op.osc][op.addr] = 1'b1;
      end
      CMD_NOTE_ON: begin
        osc_phase[0] = '0;
        osc_phase[1] = '0;
        voice_live   = 1'b1;
      end
      CMD_KILL: begin
        voice_live = 1'b0;
      end
      default: begin
        r = '0;
        if (voice_live) begin
          wb       = int'(cfg_model.mix);
          wa       = int'(MIX_MAX) - wb;
          acc      = longint'(osc_level(1'b0)) * wa + longint'(osc_level(1'b1)) * wb;
          r.sample = SAMPLE_W'(acc / int'(MIX_MAX));
          r.voice  = 1'b1;
          osc_phase[0] += cfg_model.step_a;
          osc_phase[1] += cfg_model.step_b;
        end
        expected_samples.push_back(r);
      end
    endcase
  endfunction

  task automatic send_op(dwo_op_t op);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push         <= 1'b1;
    command_i    <= op.cmd;
    oscillator_i <= op.osc;
    address_i    <= op.addr;
    wave_value_i <= op.value;
    do @(posedge clk_i); while (full);
    predict_op(op);
  endtask

  task automatic load_word(bit o, logic [ADDR_W-1:0] a, logic [SAMPLE_W-1:0] v);
    dwo_op_t op;
    op.cmd   = CMD_LOAD;
    op.osc   = o;
    op.addr  = a;
    op.value = v;
    send_op(op);
  endtask

  // Every frame a tick may read is written first, so no unwritten entry is ever read.
  task automatic prime_taps();
    wave_taps_t t;
    for (int o = 0; o < 2; o++) begin
      t = locate_taps(o[0]);
      for (int i = 0; i < 4; i++) begin
        if (!wave_known[o][t.addr[i]]) load_word(o[0], t.addr[i], SAMPLE_W'($urandom));
      end
    end
  endtask

  task automatic send_cmd(dwo_cmd_e c);
    dwo_op_t op;
    if (c == CMD_TICK) prime_taps();
    op.cmd   = c;
    op.osc   = 1'($urandom);
    op.addr  = ADDR_W'($urandom);
    op.value = SAMPLE_W'($urandom);
    send_op(op);
  endtask

  task automatic write_reg(dwo_reg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_STEP_A: cfg_model.step_a = data;
      REG_STEP_B: cfg_model.step_b = data;
      REG_LEN_A:  cfg_model.len_a  = data[LEN_W-1:0];
      REG_LEN_B:  cfg_model.len_b  = data[LEN_W-1:0];
      REG_POS_A:  cfg_model.pos_a  = data[POS_W-1:0];
      REG_POS_B:  cfg_model.pos_b  = data[POS_W-1:0];
      REG_MIX:    cfg_model.mix    = data[MIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(dwo_cfg_t c);
    write_reg(REG_STEP_A, c.step_a);
    write_reg(REG_STEP_B, c.step_b);
    write_reg(REG_LEN_A, CFG_W'(c.len_a));
    write_reg(REG_LEN_B, CFG_W'(c.len_b));
    write_reg(REG_POS_A, CFG_W'(c.pos_a));
    write_reg(REG_POS_B, CFG_W'(c.pos_b));
    write_reg(REG_MIX, CFG_W'(c.mix));
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return STEP_W'($urandom_range(0, 1 << 20));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    case ($urandom_range(9))
      0: return '0;
      1: begin
        case ($urandom_range(2))
          0:       return LEN_W'(WAVE_DEPTH);
          1:       return '1;
          default: return LEN_W'($urandom);
        endcase
      end
      default: return LEN_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_pos();
    logic [TIDX_W-1:0] idx;
    logic [FRAC_W-1:0] morph;
    idx   = ($urandom_range(9) == 0) ? TIDX_W'($urandom) : TIDX_W'($urandom_range(0, 3));
    morph = ($urandom_range(2) == 0) ? '0 : FRAC_W'($urandom);
    return {idx, morph};
  endfunction

  function automatic dwo_cfg_t random_setup();
    dwo_cfg_t c;
    c.step_a = random_step();
    c.step_b = random_step();
    c.len_a  = random_len();
    c.len_b  = random_len();
    c.pos_a  = random_pos();
    c.pos_b  = random_pos();
    case ($urandom_range(5))
      0:       c.mix = '0;
      1:       c.mix = MIX_MAX;
      default: c.mix = MIX_W'($urandom);
    endcase
    return c;
  endfunction

  task automatic test_inactive_voice();
    settle();
    send_cmd(CMD_TICK);
    send_cmd(CMD_KILL);
    send_cmd(CMD_TICK);
  endtask

  task automatic test_extreme_values();
    dwo_cfg_t c;
    settle();
    c.step_a = '1;
    c.step_b = 32'h8000_0000;
    c.len_a  = 15'd2;
    c.len_b  = '1;
    c.pos_a  = {14'd0, 16'hFFFF};
    c.pos_b  = '1;
    c.mix    = '0;
    load_config(c);
    load_word(1'b0, 14'd0, 16'sh7FFF);
    load_word(1'b0, 14'd1, 16'sh8000);
    load_word(1'b0, 14'd2, 16'sh8000);
    load_word(1'b0, 14'd3, 16'sh7FFF);
    load_word(1'b1, 14'h3FFF, 16'sh8000);
    load_word(1'b1, 14'd0, 16'sh7FFF);
    send_cmd(CMD_NOTE_ON);
    repeat (3) send_cmd(CMD_TICK);
    settle();
    c.mix = MIX_MAX;
    load_config(c);
    send_cmd(CMD_NOTE_ON);
    repeat (2) send_cmd(CMD_TICK);
  endtask

  task automatic test_wrap_and_silence();
    dwo_cfg_t c;
    settle();
    c.step_a = 32'h5555_5556;
    c.step_b = 32'h0100_0000;
    c.len_a  = 15'd3;
    c.len_b  = 15'd100;
    c.pos_a  = {14'd5461, 16'h0000};
    c.pos_b  = {14'd163, 16'h0001};
    c.mix    = 8'd1;
    load_config(c);
    send_cmd(CMD_NOTE_ON);
    repeat (4) send_cmd(CMD_TICK);
    send_cmd(CMD_KILL);
    send_cmd(CMD_TICK);
    settle();
    c.len_a = '0;
    c.len_b = '0;
    load_config(c);
    send_cmd(CMD_NOTE_ON);
    repeat (2) send_cmd(CMD_TICK);
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph % 4)
        0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1:       begin send_idle_pct = 80; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 80; end
        default: begin send_idle_pct = 15; pop_stall_pct = 15; end
      endcase
      load_config(random_setup());
      send_cmd(CMD_NOTE_ON);
      repeat (70) begin
        r = $urandom_range(99);
        if (r < 6) begin
          send_cmd(CMD_NOTE_ON);
        end else if (r < 10) begin
          send_cmd(CMD_KILL);
        end else if (r < 30) begin
          load_word(1'($urandom),
                    ($urandom_range(3) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, 79)),
                    SAMPLE_W'($urandom));
        end else begin
          send_cmd(CMD_TICK);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : drain_results
    tick_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        $error("sample_value: unexpected transaction, got %0d", sample_value_o);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_value_o !== want.sample) begin
          $error("sample_value: expected %0d, got %0d", want.sample, sample_value_o);
          mismatches++;
        end
        if (voice_on_o !== want.voice) begin
          $error("voice_on: expected %0d, got %0d", want.voice, voice_on_o);
          mismatches++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  initial begin
    cfg_model     = '0;
    cfg_model.mix = MIX_RESET;
    osc_phase[0]  = '0;
    osc_phase[1]  = '0;
    voice_live    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_inactive_voice();
    test_extreme_values();
    test_wrap_and_silence();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/dwo_pkg.sv
design/dwo_ram.sv
design/dwo_front.sv
design/dwo_osc.sv
design/dwo_back.sv
design/dual_wavetable_oscillator_mix.sv
bench/dual_wavetable_oscillator_mix_tb.sv
